### hdl/afu_pkg.sv
// Types and constants shared by the accelerometer FIFO frame unpacker.
package afu_pkg;

    // Largest entry count that a burst may request (after rounding to whole samples).
    localparam int unsigned MAX_ENTRIES = 96;

    localparam int unsigned BYTES_PER_SAMPLE = 9;
    localparam int unsigned AXIS_BITS        = 20;
    localparam int unsigned S_TDATA_BITS     = 16;
    localparam int unsigned M_TDATA_BITS     = 88;

    // Reciprocal of three for 8-bit counts: n / 3 == (n * 171) >> 9 for n < 512.
    localparam logic [7:0] RECIP3_MULT  = 8'd171;
    localparam int unsigned RECIP3_SHIFT = 9;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONE     = 2'd1,
        ST_TOO_MANY = 2'd2
    } count_status_t;

    // One result word as it leaves on the master side.
    typedef struct packed {
        kind_t                     kind;
        logic                      last;
        logic [M_TDATA_BITS-1:0]   data;
    } result_t;

endpackage

### hdl/accel_fifo_frame_unpacker.sv
// Top level of the accelerometer FIFO frame unpacker.
// Throughput: one input word per cycle while the skid slot is empty (it holds off s_tready).
// A two-deep output (register plus skid) decouples stalls; each result is registered.
// Each word is handled by short logic between the slave port and the output register.
// Reset (aresetn low, synchronous) clears the burst counters, the sticky flags and both
// output slots; the byte buffer is not reset because it is always refilled before use.
module accel_fifo_frame_unpacker
    import afu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    // Fields from bit 0 up: entry_count[7:0], data_byte[15:8].
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // Fields from bit 0 up: cmd[0].
    input  logic                    s_tuser,

    output logic                    m_tvalid,
    input  logic                    m_tready,
    // Fields from bit 0 up: count_status[1:0], sample_total[7:2], x_value[27:8],
    // y_value[47:28], z_value[67:48], sample_number[72:68], empty_seen[73],
    // empty_at[78:74], marker_fault_seen[79], marker_fault_at[84:80], zero pad[87:85].
    output logic [M_TDATA_BITS-1:0] m_tdata,
    // Fields from bit 0 up: kind[0].
    output logic                    m_tuser,
    // Carries last_sample.
    output logic                    m_tlast
);

    // Burst state.
    logic [3:0]  byte_pos_reg,     byte_pos_next;
    logic [5:0]  samples_left_reg, samples_left_next;
    logic [4:0]  sample_cnt_reg,   sample_cnt_next;
    logic [7:0]  pend_reg [0:7];

    // Sticky flags and the sample index where each was first raised.
    logic        empty_flag_reg,   empty_flag_next;
    logic [4:0]  empty_idx_reg,    empty_idx_next;
    logic        marker_flag_reg,  marker_flag_next;
    logic [4:0]  marker_idx_reg,   marker_idx_next;

    // Output register and skid slot.
    logic        out_valid_reg;
    result_t     out_reg;
    logic        skid_valid_reg;
    result_t     skid_reg;

    logic        s_accept;
    logic        out_take;
    logic        res_valid;
    result_t     res;

    // Start decode.
    logic [7:0]  entry_count;
    logic [7:0]  data_byte;
    logic [16:0] recip_prod;
    logic [6:0]  total_raw;
    logic [8:0]  rounded;
    logic [5:0]  total_sat;
    count_status_t status;

    // Sample decode.
    logic [AXIS_BITS-1:0] x_val;
    logic [AXIS_BITS-1:0] y_val;
    logic [AXIS_BITS-1:0] z_val;
    logic                 pend_write;

    assign entry_count = s_tdata[7:0];
    assign data_byte   = s_tdata[15:8];

    // The skid slot is the only thing that can hold off the slave side.
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    // Entry count rounded down to whole samples: floor(n/3) by reciprocal multiply.
    assign recip_prod = 17'(entry_count) * 17'(RECIP3_MULT);
    assign total_raw  = recip_prod[RECIP3_SHIFT+6:RECIP3_SHIFT];
    assign rounded    = 9'(total_raw) * 9'd3;
    assign total_sat  = (total_raw > 7'd63) ? 6'd63 : total_raw[5:0];

    // Axis values are the top 20 bits of each three-byte group; the ninth byte
    // comes straight from the port.
    assign x_val = {pend_reg[0], pend_reg[1], pend_reg[2][7:4]};
    assign y_val = {pend_reg[3], pend_reg[4], pend_reg[5][7:4]};
    assign z_val = {pend_reg[6], pend_reg[7], data_byte[7:4]};

    always_comb begin
        byte_pos_next     = byte_pos_reg;
        samples_left_next = samples_left_reg;
        sample_cnt_next   = sample_cnt_reg;
        empty_flag_next   = empty_flag_reg;
        empty_idx_next    = empty_idx_reg;
        marker_flag_next  = marker_flag_reg;
        marker_idx_next   = marker_idx_reg;
        res_valid         = 1'b0;
        res               = '0;
        pend_write        = 1'b0;
        status            = ST_OK;

        if (s_accept) begin
            if (cmd_t'(s_tuser) == CMD_START) begin
                // A new start drops any burst in progress; sticky flags stay.
                if (total_raw == 7'd0) begin
                    status            = ST_NONE;
                    samples_left_next = 6'd0;
                end else if (rounded > 9'(MAX_ENTRIES)) begin
                    status            = ST_TOO_MANY;
                    samples_left_next = 6'd0;
                end else begin
                    status            = ST_OK;
                    samples_left_next = total_sat;
                end
                byte_pos_next   = 4'd0;
                sample_cnt_next = 5'd0;
                res_valid       = 1'b1;
                res.kind        = KIND_STATUS;
                res.last        = 1'b0;
                res.data[1:0]   = status;
                res.data[7:2]   = samples_left_next;
                res.data[73]    = empty_flag_reg;
                res.data[78:74] = empty_idx_reg;
                res.data[79]    = marker_flag_reg;
                res.data[84:80] = marker_idx_reg;
            end else if (samples_left_reg != 6'd0) begin
                if (byte_pos_reg < 4'(BYTES_PER_SAMPLE - 1)) begin
                    // Still collecting the first eight bytes of the sample.
                    pend_write    = 1'b1;
                    byte_pos_next = byte_pos_reg + 4'd1;
                end else begin
                    // Ninth byte: check the marks carried in the third X byte.
                    if (pend_reg[2][1] && !empty_flag_reg) begin
                        empty_flag_next = 1'b1;
                        empty_idx_next  = sample_cnt_reg;
                    end
                    if (!pend_reg[2][0] && !marker_flag_reg) begin
                        marker_flag_next = 1'b1;
                        marker_idx_next  = sample_cnt_reg;
                    end
                    res_valid         = 1'b1;
                    res.kind          = KIND_SAMPLE;
                    res.last          = (samples_left_reg == 6'd1);
                    res.data[27:8]    = x_val;
                    res.data[47:28]   = y_val;
                    res.data[67:48]   = z_val;
                    res.data[72:68]   = sample_cnt_reg;
                    res.data[73]      = empty_flag_next;
                    res.data[78:74]   = empty_idx_next;
                    res.data[79]      = marker_flag_next;
                    res.data[84:80]   = marker_idx_next;
                    samples_left_next = samples_left_reg - 6'd1;
                    sample_cnt_next   = sample_cnt_reg + 5'd1;
                    byte_pos_next     = 4'd0;
                end
            end
            // A data word with no samples expected is dropped without a result.
        end
    end

    // Byte buffer: each slot is written before the ninth byte reads it.
    always_ff @(posedge aclk) begin
        if (pend_write) begin
            pend_reg[byte_pos_reg[2:0]] <= data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg     <= 4'd0;
            samples_left_reg <= 6'd0;
            sample_cnt_reg   <= 5'd0;
            empty_flag_reg   <= 1'b0;
            empty_idx_reg    <= 5'd0;
            marker_flag_reg  <= 1'b0;
            marker_idx_reg   <= 5'd0;
        end else begin
            byte_pos_reg     <= byte_pos_next;
            samples_left_reg <= samples_left_next;
            sample_cnt_reg   <= sample_cnt_next;
            empty_flag_reg   <= empty_flag_next;
            empty_idx_reg    <= empty_idx_next;
            marker_flag_reg  <= marker_flag_next;
            marker_idx_reg   <= marker_idx_next;
        end
    end

    // Output register with a skid slot behind it. The skid fills only when a
    // new result arrives while the output word is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (res_valid) begin
                out_reg <= res;
            end
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

### tb/accel_fifo_frame_unpacker_tb.sv
// Self-checking testbench for the accelerometer FIFO frame unpacker.
module accel_fifo_frame_unpacker_tb
    import afu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped here if the result stream stalls for good.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Input words for the random part, counted without the stray bytes sent after a burst.
    localparam int unsigned RANDOM_WORDS = 830;

    // One predicted result word, split into the fields that travel on the master side.
    typedef struct packed {
        kind_t         kind;
        count_status_t status;
        logic [5:0]    total;
        logic [19:0]   x_val;
        logic [19:0]   y_val;
        logic [19:0]   z_val;
        logic [4:0]    number;
        logic          last;
        logic          empty_seen;
        logic [4:0]    empty_at;
        logic          fault_seen;
        logic [4:0]    fault_at;
    } frame_word_t;

    // Every input starts at a known value; reset is held low from time zero.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Own copy of the unpacker state, advanced once per accepted input word.
    logic [3:0]  byte_pos;
    logic [5:0]  samples_left;
    logic [4:0]  sample_idx;
    logic [7:0]  held_bytes [8];
    logic        empty_flag;
    logic [4:0]  empty_idx;
    logic        marker_flag;
    logic [4:0]  marker_idx;

    // Result words that the block still owes, oldest first.
    frame_word_t unpacked_q[$];

    int unsigned mismatches    = 0;
    int unsigned status_words  = 0;
    int unsigned sample_words  = 0;
    int unsigned ignored_bytes = 0;
    int unsigned cycle_count   = 0;
    int unsigned stall_left    = 0;
    // While set, neither side inserts gaps, so words move back to back.
    bit          steady        = 1'b0;

    accel_fifo_frame_unpacker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // Fields from bit 0 up: entry_count[7:0], data_byte[15:8].
        .s_tuser  (s_tuser),   // Fields from bit 0 up: cmd[0].
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // Fields from bit 0 up: count_status, sample_total, x, y, z,
                               // sample_number, empty_seen, empty_at, marker_fault_seen,
                               // marker_fault_at, zero pad.
        .m_tuser  (m_tuser),   // Fields from bit 0 up: kind[0].
        .m_tlast  (m_tlast)    // Carries last_sample.
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Predicts what one accepted input word causes. A start word always answers with a
    // status word; a data byte only counts while a burst is open, and the ninth byte of
    // a sample produces the decoded sample.
    function void unpack_fifo_word(input cmd_t cmd, input logic [7:0] count,
                                   input logic [7:0] dbyte);
        frame_word_t w;
        int unsigned entries;
        bit          produced;
        w        = '0;
        produced = 1'b0;
        if (cmd == CMD_START) begin
            // Only whole samples of three entries are read.
            entries    = count - count % 3;
            byte_pos   = '0;
            sample_idx = '0;
            w.kind     = KIND_STATUS;
            if (entries == 0) begin
                w.status = ST_NONE;
            end else if (entries > MAX_ENTRIES) begin
                w.status = ST_TOO_MANY;
            end else begin
                w.status = ST_OK;
                w.total  = (entries / 3 > 63) ? 6'd63 : 6'(entries / 3);
            end
            samples_left = w.total;
            produced     = 1'b1;
        end else if (samples_left == 0) begin
            ignored_bytes++;
        end else if (byte_pos < 8) begin
            held_bytes[byte_pos] = dbyte;
            byte_pos++;
        end else begin
            // The third X byte carries the empty mark in bit 1 and the X mark in bit 0.
            if (held_bytes[2][1] && !empty_flag) begin
                empty_flag = 1'b1;
                empty_idx  = sample_idx;
            end
            if (!held_bytes[2][0] && !marker_flag) begin
                marker_flag = 1'b1;
                marker_idx  = sample_idx;
            end
            w.kind   = KIND_SAMPLE;
            w.x_val  = {held_bytes[0], held_bytes[1], held_bytes[2][7:4]};
            w.y_val  = {held_bytes[3], held_bytes[4], held_bytes[5][7:4]};
            w.z_val  = {held_bytes[6], held_bytes[7], dbyte[7:4]};
            w.number = sample_idx;
            w.last   = (samples_left == 1);
            samples_left--;
            sample_idx++;
            byte_pos = '0;
            produced = 1'b1;
        end
        if (produced) begin
            // Both kinds of result report the sticky flags as they stand now.
            w.empty_seen = empty_flag;
            w.empty_at   = empty_idx;
            w.fault_seen = marker_flag;
            w.fault_at   = marker_idx;
            unpacked_q.push_back(w);
        end
    endfunction

    function void check_field(input string name, input logic [19:0] want,
                              input logic [19:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // The predictor follows the slave side. Values are read at the clock edge, before
    // any register of the block or of this bench changes in that step.
    always @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos     = '0;
            samples_left = '0;
            sample_idx   = '0;
            empty_flag   = 1'b0;
            empty_idx    = '0;
            marker_flag  = 1'b0;
            marker_idx   = '0;
        end else if (s_tvalid && s_tready) begin
            unpack_fifo_word(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
        end
    end

    // Each result word leaving the master side is held against the oldest prediction.
    // A word accepted in this step was caused by an input accepted at an earlier edge,
    // so its prediction is already queued whatever order the two blocks run in.
    always @(posedge aclk) begin
        frame_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (unpacked_q.size() == 0) begin
                $error("result word with no prediction waiting: kind %0d, data 0x%0h",
                       m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = unpacked_q.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("count_status", want.status, m_tdata[1:0]);
                check_field("sample_total", want.total, m_tdata[7:2]);
                check_field("x_value", want.x_val, m_tdata[27:8]);
                check_field("y_value", want.y_val, m_tdata[47:28]);
                check_field("z_value", want.z_val, m_tdata[67:48]);
                check_field("sample_number", want.number, m_tdata[72:68]);
                check_field("last_sample", want.last, m_tlast);
                check_field("empty_seen", want.empty_seen, m_tdata[73]);
                check_field("empty_at", want.empty_at, m_tdata[78:74]);
                check_field("marker_fault_seen", want.fault_seen, m_tdata[79]);
                check_field("marker_fault_at", want.fault_at, m_tdata[84:80]);
                check_field("zero pad", 20'd0, m_tdata[87:85]);
                if (want.kind == KIND_STATUS) begin
                    status_words++;
                end else begin
                    sample_words++;
                end
            end
        end
    end

    // The receiver draws a random stall after every word it takes, except during steady
    // stretches. Exactly one assignment to m_tready per edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                stall_left = steady ? 0 : $urandom_range(0, 7);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("accel_fifo_frame_unpacker verification failed");
            $finish;
        end
    end

    // Offers one input word after a random gap and returns at the edge where it is taken.
    // When the gap is zero, valid simply stays high from the previous word.
    task automatic send_word(input cmd_t cmd, input logic [7:0] count,
                             input logic [7:0] dbyte);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dbyte, count};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Data bytes straight after reset find no open burst and must vanish silently.
    task automatic test_stray_bytes();
        send_word(CMD_DATA, 8'h00, 8'hFF);
        send_word(CMD_DATA, 8'hFF, 8'h00);
    endtask

    // Counts that round to nothing, exceed the limit, or round down onto the limit.
    // The last one opens a full burst that the next test abandons before any byte.
    task automatic test_count_rounding();
        send_word(CMD_START, 8'd0, 8'h00);
        send_word(CMD_START, 8'd2, 8'hFF);
        send_word(CMD_START, 8'd99, 8'h00);
        send_word(CMD_START, 8'd255, 8'hFF);
        send_word(CMD_START, 8'd97, 8'h00);
    endtask

    // One sample with X at the negative limit, Y at the positive limit and Z at -1.
    // The X mark is present and the empty mark clear, so no sticky flag rises.
    task automatic test_extreme_sample();
        send_word(CMD_START, 8'd3, 8'hFF);
        send_word(CMD_DATA, 8'h00, 8'h80);
        send_word(CMD_DATA, 8'h00, 8'h00);
        send_word(CMD_DATA, 8'h00, 8'h01);
        send_word(CMD_DATA, 8'h00, 8'h7F);
        send_word(CMD_DATA, 8'h00, 8'hFF);
        send_word(CMD_DATA, 8'h00, 8'hF0);
        send_word(CMD_DATA, 8'h00, 8'hFF);
        send_word(CMD_DATA, 8'h00, 8'hFF);
        send_word(CMD_DATA, 8'hFF, 8'hFF);
    endtask

    // A new start in the middle of a sample drops the bytes gathered so far.
    task automatic test_restart_mid_sample();
        int unsigned n;
        send_word(CMD_START, 8'd6, 8'h00);
        for (n = 0; n < 4; n++) begin
            send_word(CMD_DATA, 8'($urandom), 8'($urandom));
        end
        send_word(CMD_START, 8'd6, 8'h00);
    endtask

    // Mostly well-formed bursts of a few samples with random content, a few full-size
    // bursts, and some noise: arbitrary counts, bursts cut short, and stray bytes.
    // The X mark is usually present so that the first missing mark lands at a random
    // sample index; the empty mark is rare for the same reason.
    task automatic test_random_bursts();
        int unsigned sent;
        int unsigned samples;
        int unsigned cut;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  count;
        logic [7:0]  dbyte;
        bit          first;
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_WORDS) begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            if (first || pick < 3) begin
                count = 8'(96 + $urandom_range(0, 2));
            end else if (pick < 78) begin
                count = 8'($urandom_range(3, 17));
            end else begin
                count = 8'($urandom_range(0, 255));
            end
            first = 1'b0;
            send_word(CMD_START, count, 8'($urandom));
            sent++;
            samples = (count / 3 * 3 > MAX_ENTRIES) ? 0 : count / 3;
            cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, samples * 9)
                                                  : samples * 9;
            // The final burst is cut short so the word count stays near its target.
            if (cut > RANDOM_WORDS - sent) begin
                cut = RANDOM_WORDS - sent;
            end
            for (n = 0; n < cut; n++) begin
                dbyte = 8'($urandom);
                if (n % 9 == 2) begin
                    dbyte[0] = ($urandom_range(0, 39) != 0);
                    dbyte[1] = ($urandom_range(0, 19) == 0);
                end
                send_word(CMD_DATA, 8'($urandom), dbyte);
                sent++;
            end
            // Stray bytes after the burst are not counted; they are ignored unless a cut burst is still open.
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_word(CMD_DATA, 8'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_stray_bytes();
        test_count_rounding();
        test_extreme_sample();
        test_restart_mid_sample();
        test_random_bursts();

        // Stop offering words, let every owed result drain, then watch a little longer
        // for anything the block sends without cause.
        s_tvalid <= 1'b0;
        steady = 1'b1;
        while (unpacked_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Checked %0d status words and %0d decoded samples; %0d bytes came outside a burst.",
                 status_words, sample_words, ignored_bytes);
        $display("Sticky state at the end: empty %0d at sample %0d, missing mark %0d at sample %0d.",
                 empty_flag, empty_idx, marker_flag, marker_idx);
        if (mismatches == 0) begin
            $display("accel_fifo_frame_unpacker verification clean");
        end else begin
            $display("accel_fifo_frame_unpacker verification failed");
        end
        $finish;
    end

endmodule
